// ===== design/longest_zero_sum_run_defines.svh =====
// Assertion macros used by the RTL of the zero-sum run finder.
`ifndef LONGEST_ZERO_SUM_RUN_DEFINES_SVH
`define LONGEST_ZERO_SUM_RUN_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define LZSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzsr check failed");

// Next-cycle implication, off while reset is asserted.
`define LZSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzsr check failed");

`endif

// ===== design/lzsr_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsr_pkg
// Widths, limits and the table entry type of the zero-sum run finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lzsr_pkg;

    localparam int MAX_ITEMS  = 256;
    localparam int VALUE_BITS = 16;

    // Input field width and result field width are fixed by the interface.
    localparam int IN_W   = 16;
    localparam int LEN_W  = 9;

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
    // MAX_ITEMS values of VALUE_BITS bits each cannot overflow this sum.
    localparam int SUM_W  = VALUE_BITS + ADDR_W;

    typedef struct packed {
        logic [SUM_W-1:0]  key;
        logic [ADDR_W-1:0] pos;
    } t_entry;

endpackage

`default_nettype wire

// ===== design/longest_zero_sum_run.sv =====
// ----------------------------------------------------------------------------
// longest_zero_sum_run
// Longest contiguous run of a signed sequence whose elements sum to zero.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one signed element per
// transaction in i_value, with i_last set on the final element. Output
// channel (o_out_valid / i_out_ready) carries one result per sequence:
// o_longest_length and o_overflow.
// Each accepted element's prefix sum is searched for among the distinct
// nonzero prefix sums stored so far in the sequence (at most MAX_ITEMS)
// before the next element can be accepted; a new prefix sum takes the
// longest. A zero prefix sum skips the search. The search of the prefix
// table is linear: one single-port read and one key compare per entry.
// Elements past MAX_ITEMS are dropped and only set the overflow flag.
// The result is presented in the cycle after the final element's search ends
// and is held until taken; no new element is accepted while it waits.
// Reset clears the sum, counters, best length and table fill count; the
// table memory itself is not cleared, as only filled entries are read.
// Taking the result clears the sum, element index, fill count, best length
// and overflow flag for the next sequence.
`timescale 1ns / 1ps
`default_nettype none
`include "longest_zero_sum_run_defines.svh"

module longest_zero_sum_run (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic signed [lzsr_pkg::IN_W-1:0] i_value,
    input  wire logic                        i_last,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [lzsr_pkg::LEN_W-1:0]       o_longest_length,
    output logic                             o_overflow
);

    localparam int SUM_W  = lzsr_pkg::SUM_W;
    localparam int IDX_W  = lzsr_pkg::IDX_W;
    localparam int ADDR_W = lzsr_pkg::ADDR_W;
    localparam int VB     = lzsr_pkg::VALUE_BITS;

    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(lzsr_pkg::MAX_ITEMS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ABSORB = 3'd1;
    localparam logic [2:0] S_LOOK   = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [SUM_W-1:0]  r_sum,   n_sum;
    logic [IDX_W-1:0]  r_index, n_index;
    logic [IDX_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_k,     n_k;
    logic [IDX_W-1:0]  r_best,  n_best;
    logic              r_ovf,   n_ovf;
    logic              r_last,  n_last;

    lzsr_pkg::t_entry  r_mem [lzsr_pkg::MAX_ITEMS];
    lzsr_pkg::t_entry  r_rd;
    lzsr_pkg::t_entry  w_wr_data;
    logic              w_wr_en;

    logic [SUM_W-1:0]  w_value_ext;
    logic [IDX_W-1:0]  w_span;
    logic [IDX_W-1:0]  w_whole;

    // Take VALUE_BITS of the input and sign-extend to the sum width.
    assign w_value_ext = {{(SUM_W-VB){i_value[VB-1]}}, i_value[VB-1:0]};
    assign w_span      = r_index - {1'b0, r_rd.pos};
    assign w_whole     = r_index + IDX_W'(1);

    assign w_wr_data.key = r_sum;
    assign w_wr_data.pos = r_index[ADDR_W-1:0];

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_longest_length = lzsr_pkg::LEN_W'(r_best);
    assign o_overflow       = r_ovf;

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_index = r_index;
        n_count = r_count;
        n_k     = r_k;
        n_best  = r_best;
        n_ovf   = r_ovf;
        n_last  = r_last;
        w_wr_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_last;
                    if (r_index < MAX_IDX) begin
                        n_sum   = r_sum + w_value_ext;
                        n_state = S_ABSORB;
                    end else begin
                        // drop the element, only flag it
                        n_ovf   = 1'b1;
                        n_state = i_last ? S_OUT : S_IDLE;
                    end
                end
            end
            S_ABSORB: begin
                if (r_sum == '0) begin
                    if (w_whole > r_best) begin
                        n_best = w_whole;
                    end
                    n_index = w_whole;
                    n_state = r_last ? S_OUT : S_IDLE;
                end else begin
                    n_k     = '0;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (r_k == r_count) begin
                    // new prefix sum: record where it first appeared
                    w_wr_en = 1'b1;
                    n_count = r_count + IDX_W'(1);
                    n_index = w_whole;
                    n_state = r_last ? S_OUT : S_IDLE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_rd.key == r_sum) begin
                    if (w_span > r_best) begin
                        n_best = w_span;
                    end
                    n_index = w_whole;
                    n_state = r_last ? S_OUT : S_IDLE;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = S_LOOK;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_sum   = '0;
                    n_index = '0;
                    n_count = '0;
                    n_best  = '0;
                    n_ovf   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= '0;
            r_index <= '0;
            r_count <= '0;
            r_k     <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_index <= n_index;
            r_count <= n_count;
            r_k     <= n_k;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
        end
    end

    // Prefix table: one write port at the fill count, one registered read.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_count[ADDR_W-1:0]] <= w_wr_data;
        end
        r_rd <= r_mem[r_k[ADDR_W-1:0]];
    end

    `LZSR_ASSERT_NOW(a_ready_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `LZSR_ASSERT_NOW(a_fill_le_index, i_clk, i_rst_n, 1'b1, r_count <= r_index)
    `LZSR_ASSERT_NOW(a_best_le_index, i_clk, i_rst_n, r_state == S_IDLE,
        r_best <= r_index)
    `LZSR_ASSERT_NEXT(a_clear_on_out, i_clk, i_rst_n, o_out_valid && i_out_ready,
        r_index == '0 && r_count == '0 && r_best == '0 && !r_ovf)

endmodule

`default_nettype wire
